FILE: sv/pregrasp_point_offset_defines.svh
// Assertion macros used by ppo_checker, the checker of the pre-grasp block.
`ifndef PREGRASP_POINT_OFFSET_DEFINES_SVH
`define PREGRASP_POINT_OFFSET_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked while reset is asserted.
`define PPO_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ppo_pkg.sv
package ppo_pkg;

    localparam int DATA_W        = 32;
    localparam int DIST_W        = 31;
    localparam int SQ_W          = 64;
    localparam int ROOT_W        = 32;
    localparam int HALF_W        = 5;
    localparam int REM_W         = 35;
    localparam int GOAL_W        = 34;
    localparam int NUM_LANES     = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_ADDR_W    = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_APPROACH_DISTANCE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIFT_HEIGHT       = 1'd1;

endpackage

FILE: sv/ppo_norm.sv
// Axis length unit: magnitudes, squares, sum, even normalization and a
// one-bit-per-stage square root. A side payload rides along unchanged.
module ppo_norm #(
    parameter int PW = 96
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_vld,
    input  logic [3*ppo_pkg::DATA_W-1:0]          axis,
    input  logic [PW-1:0]                         in_pay,
    output logic                                  out_vld,
    output logic [ppo_pkg::ROOT_W-1:0]            out_root,
    output logic [ppo_pkg::HALF_W-1:0]            out_half,
    output logic                                  out_zero,
    output logic [3*ppo_pkg::DATA_W-1:0]          out_mag,
    output logic [2:0]                            out_neg,
    output logic [PW-1:0]                         out_pay
);
    localparam int DW     = ppo_pkg::DATA_W;
    localparam int SQ_W   = ppo_pkg::SQ_W;
    localparam int ROOT_W = ppo_pkg::ROOT_W;
    localparam int HALF_W = ppo_pkg::HALF_W;
    localparam int REM_W  = ppo_pkg::REM_W;
    localparam int SIDE_W = PW + 3*DW + 3;
    localparam int TAIL_W = SIDE_W + 1 + HALF_W;
    localparam int NSTG   = 4 + ROOT_W + 1;

    logic [NSTG-1:0]      vld_reg;
    logic [3*DW-1:0]      mag1_reg, mag1_next;
    logic [2:0]           neg1_reg, neg1_next;
    logic [PW-1:0]        pay1_reg;
    logic [SQ_W-1:0]      sq2_reg [3];
    logic [SQ_W-1:0]      sq2_next [3];
    logic [SIDE_W-1:0]    side2_reg, side3_reg, side4_reg;
    logic [SQ_W-1:0]      sum3_reg, sum4_reg;
    logic [HALF_W-1:0]    half4_reg, half4_next;
    logic                 zero4_reg;
    logic [5:0]           msb_pos;
    logic [5:0]           lead;

    logic [SQ_W-1:0]      rad_reg   [ROOT_W+1];
    logic [SQ_W-1:0]      rad_next  [ROOT_W+1];
    logic [REM_W-1:0]     rem_reg   [ROOT_W+1];
    logic [REM_W-1:0]     rem_next  [ROOT_W+1];
    logic [ROOT_W-1:0]    root_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]    root_next [ROOT_W+1];
    logic [TAIL_W-1:0]    tail_reg  [ROOT_W+1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg1_next[i] = axis[i*DW + DW - 1];
            mag1_next[i*DW +: DW] = axis[i*DW + DW - 1] ? (~axis[i*DW +: DW] + 1'b1)
                                                         : axis[i*DW +: DW];
            sq2_next[i] = SQ_W'(mag1_reg[i*DW +: DW]) * SQ_W'(mag1_reg[i*DW +: DW]);
        end
    end

    // Position of the leading one; the normalizing shift is the even part
    // of the leading zero count.
    always_comb begin
        msb_pos = '0;
        for (int b = 0; b < SQ_W; b++) begin
            if (sum3_reg[b]) begin
                msb_pos = 6'(b);
            end
        end
        lead       = 6'(SQ_W - 1) - msb_pos;
        half4_next = lead[5:1];
    end

    always_comb begin
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        rad_next[0]  = sum4_reg << {half4_reg, 1'b0};
        rem_next[0]  = '0;
        root_next[0] = '0;
        for (int j = 1; j <= ROOT_W; j++) begin
            cur   = {rem_reg[j-1][REM_W-3:0], rad_reg[j-1][SQ_W-1:SQ_W-2]};
            trial = REM_W'({root_reg[j-1], 2'b01});
            rad_next[j] = rad_reg[j-1] << 2;
            if (cur >= trial) begin
                rem_next[j]  = cur - trial;
                root_next[j] = {root_reg[j-1][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[j]  = cur;
                root_next[j] = {root_reg[j-1][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= mag1_next;
            neg1_reg  <= neg1_next;
            pay1_reg  <= in_pay;
            for (int i = 0; i < 3; i++) begin
                sq2_reg[i] <= sq2_next[i];
            end
            side2_reg <= {pay1_reg, mag1_reg, neg1_reg};
            sum3_reg  <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            side3_reg <= side2_reg;
            sum4_reg  <= sum3_reg;
            half4_reg <= half4_next;
            zero4_reg <= (sum3_reg == '0);
            side4_reg <= side3_reg;
            tail_reg[0] <= {side4_reg, zero4_reg, half4_reg};
            for (int j = 0; j <= ROOT_W; j++) begin
                rad_reg[j]  <= rad_next[j];
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
            end
            for (int j = 1; j <= ROOT_W; j++) begin
                tail_reg[j] <= tail_reg[j-1];
            end
        end
    end

    assign out_vld  = vld_reg[NSTG-1];
    assign out_root = root_reg[ROOT_W];
    assign out_half = tail_reg[ROOT_W][HALF_W-1:0];
    assign out_zero = tail_reg[ROOT_W][HALF_W];
    assign out_neg  = tail_reg[ROOT_W][HALF_W+1 +: 3];
    assign out_mag  = tail_reg[ROOT_W][HALF_W+4 +: 3*DW];
    assign out_pay  = tail_reg[ROOT_W][HALF_W+4+3*DW +: PW];

endmodule

FILE: sv/ppo_lane.sv
// One axis component: restoring divide by the root, one quotient bit per
// stage, then scale by the distance and subtract from the object point.
module ppo_lane #(
    parameter int FRAC_BITS = ppo_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_vld,
    input  logic                                in_tag,
    input  logic [ppo_pkg::DATA_W-1:0]          in_mag,
    input  logic [ppo_pkg::HALF_W-1:0]          in_half,
    input  logic [ppo_pkg::ROOT_W-1:0]          in_root,
    input  logic signed [ppo_pkg::DATA_W-1:0]   in_obj,
    input  logic                                in_neg,
    input  logic [ppo_pkg::DIST_W-1:0]          approach_dist,
    output logic                                out_vld,
    output logic                                out_tag,
    output logic signed [ppo_pkg::GOAL_W-1:0]   out_goal
);
    localparam int DW     = ppo_pkg::DATA_W;
    localparam int GOAL_W = ppo_pkg::GOAL_W;
    localparam int ROOT_W = ppo_pkg::ROOT_W;
    localparam int QW     = FRAC_BITS + 1;
    localparam int NW     = FRAC_BITS + DW + 1;
    localparam int SH_W   = $clog2(FRAC_BITS + DW);
    localparam int PROD_W = ppo_pkg::DIST_W + QW;

    logic [QW+2:0]               vld_reg;
    logic [NW-1:0]               num_reg  [QW+1];
    logic [NW-1:0]               num_next [QW+1];
    logic [QW-1:0]               q_reg    [QW+1];
    logic [QW-1:0]               q_next   [QW+1];
    logic [ROOT_W-1:0]           root_reg [QW+1];
    logic signed [DW-1:0]        obj_reg  [QW+1];
    logic [QW:0]                 neg_reg;
    logic [QW:0]                 tag_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic signed [DW-1:0]        objp_reg;
    logic                        negp_reg, tagp_reg;
    logic signed [GOAL_W-1:0]    goal_reg, goal_next;
    logic                        tagg_reg;
    logic signed [GOAL_W-1:0]    off_s;

    always_comb begin
        logic [NW-1:0] dv;
        num_next[0] = NW'(in_mag) << (SH_W'(FRAC_BITS) + SH_W'(in_half));
        q_next[0]   = '0;
        for (int j = 1; j <= QW; j++) begin
            dv = NW'(root_reg[j-1]) << (QW - j);
            if (num_reg[j-1] >= dv) begin
                num_next[j] = num_reg[j-1] - dv;
                q_next[j]   = q_reg[j-1] | (QW'(1) << (QW - j));
            end else begin
                num_next[j] = num_reg[j-1];
                q_next[j]   = q_reg[j-1];
            end
        end
    end

    always_comb begin
        off_s     = $signed({2'b00, prod_reg[FRAC_BITS +: DW]});
        goal_next = $signed({{2{objp_reg[DW-1]}}, objp_reg}) - (negp_reg ? -off_s : off_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QW+1:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j <= QW; j++) begin
                num_reg[j] <= num_next[j];
                q_reg[j]   <= q_next[j];
            end
            root_reg[0] <= in_root;
            obj_reg[0]  <= in_obj;
            neg_reg[0]  <= in_neg;
            tag_reg[0]  <= in_tag;
            for (int j = 1; j <= QW; j++) begin
                root_reg[j] <= root_reg[j-1];
                obj_reg[j]  <= obj_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
                tag_reg[j]  <= tag_reg[j-1];
            end
            prod_reg <= PROD_W'(approach_dist) * PROD_W'(q_reg[QW]);
            objp_reg <= obj_reg[QW];
            negp_reg <= neg_reg[QW];
            tagp_reg <= tag_reg[QW];
            goal_reg <= goal_next;
            tagg_reg <= tagp_reg;
        end
    end

    assign out_vld  = vld_reg[QW+2];
    assign out_tag  = tagg_reg;
    assign out_goal = goal_reg;

endmodule

FILE: sv/ppo_merge.sv
// Merge of the three lanes: lift on z, saturation, zero-axis override and
// the output register.
module ppo_merge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic                                 in_zero,
    input  logic signed [ppo_pkg::GOAL_W-1:0]    goal_x,
    input  logic signed [ppo_pkg::GOAL_W-1:0]    goal_y,
    input  logic signed [ppo_pkg::GOAL_W-1:0]    goal_z,
    input  logic signed [ppo_pkg::DATA_W-1:0]    lift,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [3*ppo_pkg::DATA_W-1:0]         m_tdata,
    output logic                                 m_tuser
);
    localparam int DW    = ppo_pkg::DATA_W;
    localparam int SUM_W = ppo_pkg::GOAL_W + 1;

    function automatic logic [DW-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed({{(SUM_W-DW){1'b0}}, 1'b0, {(DW-1){1'b1}}});
        lo = $signed({{(SUM_W-DW){1'b1}}, 1'b1, {(DW-1){1'b0}}});
        if (v > hi) begin
            return hi[DW-1:0];
        end else if (v < lo) begin
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [3*DW-1:0]         m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;
    logic signed [SUM_W-1:0] z_sum;

    always_comb begin
        z_sum = $signed({goal_z[ppo_pkg::GOAL_W-1], goal_z})
              + $signed({{(SUM_W-DW){lift[DW-1]}}, lift});
        if (in_zero) begin
            m_tdata_next = '0;
            m_tuser_next = 1'b0;
        end else begin
            m_tdata_next = {sat_word(z_sum),
                            sat_word($signed({goal_y[ppo_pkg::GOAL_W-1], goal_y})),
                            sat_word($signed({goal_x[ppo_pkg::GOAL_W-1], goal_x}))};
            m_tuser_next = 1'b1;
        end
        if (en && in_vld) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_vld) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: sv/pregrasp_point_offset.sv
// Pre-grasp point offset.
// The s_ channel carries one item per grasp: the object point and the approach
// axis, six signed fixed-point words. The m_ channel returns one item per
// input item, in order: the goal point backed off along the normalized axis
// by approach_distance, with lift_height added to z, each word saturated.
// m_tuser is 0 (and m_tdata all zero) when the axis was the zero vector.
// Both registers are written through the cfg_ port; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Throughput is one item per cycle unless the receiver stalls. An item passes
// FRAC_BITS + 42 registers, the first loaded at the accepting edge: 37 stages
// for the squares, normalization and the one-bit-per-stage square root,
// FRAC_BITS + 2 stages for the per-lane restoring divider (numerator load plus
// one quotient bit per stage), one multiply stage, one subtract stage and the
// output register. Reset (aresetn low, synchronous) empties the pipeline and
// clears both registers to zero. When the receiver stalls, the output register
// holds its item and the pipeline keeps moving as long as its last stage is
// empty; once a finished item waits behind the held one, s_tready drops until
// the receiver takes the output.
module pregrasp_point_offset #(
    parameter int FRAC_BITS = ppo_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // object_x, object_y, object_z, axis_x, axis_y, axis_z (lowest first)
    input  logic [6*ppo_pkg::DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // goal_x, goal_y, goal_z (lowest first)
    output logic [3*ppo_pkg::DATA_W-1:0]       m_tdata,
    // goal_valid
    output logic                               m_tuser,
    input  logic                               cfg_we,
    input  logic [ppo_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ppo_pkg::DATA_W-1:0]         cfg_wdata
);
    localparam int DW = ppo_pkg::DATA_W;

    logic [ppo_pkg::DIST_W-1:0]        approach_distance_reg;
    logic signed [DW-1:0]              lift_height_reg;

    logic                              en;
    logic                              norm_vld;
    logic [ppo_pkg::ROOT_W-1:0]        norm_root;
    logic [ppo_pkg::HALF_W-1:0]        norm_half;
    logic                              norm_zero;
    logic [3*DW-1:0]                   norm_mag;
    logic [2:0]                        norm_neg;
    logic [3*DW-1:0]                   norm_obj;
    logic [ppo_pkg::NUM_LANES-1:0]     lane_vld;
    logic [ppo_pkg::NUM_LANES-1:0]     lane_tag;
    logic signed [ppo_pkg::GOAL_W-1:0] lane_goal [ppo_pkg::NUM_LANES];

    // Register writes; an index past the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            approach_distance_reg <= '0;
            lift_height_reg       <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                ppo_pkg::REG_APPROACH_DISTANCE: begin
                    approach_distance_reg <= cfg_wdata[ppo_pkg::DIST_W-1:0];
                end
                ppo_pkg::REG_LIFT_HEIGHT: begin
                    lift_height_reg <= $signed(cfg_wdata);
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves together unless a finished item in the last
    // lane stage has nowhere to go.
    assign en       = m_tready || !m_tvalid || !lane_vld[0];
    assign s_tready = en;

    ppo_norm #(
        .PW(3*DW)
    ) u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_tvalid),
        .axis     (s_tdata[6*DW-1:3*DW]),
        .in_pay   (s_tdata[3*DW-1:0]),
        .out_vld  (norm_vld),
        .out_root (norm_root),
        .out_half (norm_half),
        .out_zero (norm_zero),
        .out_mag  (norm_mag),
        .out_neg  (norm_neg),
        .out_pay  (norm_obj)
    );

    // One lane per axis component; each lane also carries the zero-axis flag.
    for (genvar i = 0; i < ppo_pkg::NUM_LANES; i++) begin : g_lane
        ppo_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .en            (en),
            .in_vld        (norm_vld),
            .in_tag        (norm_zero),
            .in_mag        (norm_mag[i*DW +: DW]),
            .in_half       (norm_half),
            .in_root       (norm_root),
            .in_obj        ($signed(norm_obj[i*DW +: DW])),
            .in_neg        (norm_neg[i]),
            .approach_dist (approach_distance_reg),
            .out_vld       (lane_vld[i]),
            .out_tag       (lane_tag[i]),
            .out_goal      (lane_goal[i])
        );
    end

    ppo_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (lane_vld[0] && lane_vld[1] && lane_vld[2]),
        .in_zero  (lane_tag[0] || lane_tag[1] || lane_tag[2]),
        .goal_x   (lane_goal[0]),
        .goal_y   (lane_goal[1]),
        .goal_z   (lane_goal[2]),
        .lift     (lift_height_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: sv/ppo_checker.sv
`include "pregrasp_point_offset_defines.svh"

module ppo_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [3*ppo_pkg::DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);

    `PPO_ASSERT_NEXT(a_reset_empties, aclk, !aresetn, !m_tvalid, "output valid after reset")

    `PPO_ASSERT_NEXT(a_stall_holds, aclk, aresetn && m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output item changed")

    `PPO_ASSERT_SAME(a_invalid_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0, "zero-axis item carries nonzero data")

    `PPO_ASSERT_SAME(a_ready_when_free, aclk, aresetn, !m_tvalid || m_tready, s_tready, "input stalled while output slot is free")

endmodule

bind pregrasp_point_offset ppo_checker u_ppo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: verif/pregrasp_point_offset_tb.sv
module pregrasp_point_offset_tb;

    localparam int DATA_W     = ppo_pkg::DATA_W;
    localparam int DIST_W     = ppo_pkg::DIST_W;
    localparam int CFG_ADDR_W = ppo_pkg::CFG_ADDR_W;
    localparam logic [CFG_ADDR_W-1:0] REG_APPROACH_DISTANCE = ppo_pkg::REG_APPROACH_DISTANCE;
    localparam logic [CFG_ADDR_W-1:0] REG_LIFT_HEIGHT       = ppo_pkg::REG_LIFT_HEIGHT;

    localparam int FRAC     = ppo_pkg::FRAC_BITS_DEF;
    localparam int LATENCY  = FRAC + 41;
    localparam int SETTLE   = LATENCY + 20;
    localparam int WD_LIMIT = 6000;

    typedef struct {
        logic signed [DATA_W-1:0] gx;
        logic signed [DATA_W-1:0] gy;
        logic signed [DATA_W-1:0] gz;
        logic                     valid;
    } goal_t;

    // The scoreboard keeps its own copy of both registers and predicts the goal
    // point of every accepted item, then matches results in order.
    class goal_scoreboard;
        logic [DIST_W-1:0]        distance;
        logic signed [DATA_W-1:0] lift;
        goal_t                    goals_due[$];
        int                       errors;

        function void reset_regs();
            distance = '0;
            lift     = '0;
            errors   = 0;
            goals_due.delete();
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [DATA_W-1:0] value);
            if (idx == REG_APPROACH_DISTANCE) begin
                distance = value[DIST_W-1:0];
            end else if (idx == REG_LIFT_HEIGHT) begin
                lift = value;
            end
        endfunction

        // Bit-serial integer square root of a 64-bit value.
        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned rem;
            longint unsigned root;
            longint unsigned one;
            rem  = v;
            root = 0;
            one  = 64'd1 << 62;
            while (one > rem) one = one >> 2;
            while (one != 0) begin
                if (rem >= root + one) begin
                    rem  = rem - (root + one);
                    root = (root >> 1) + one;
                end else begin
                    root = root >> 1;
                end
                one = one >> 2;
            end
            return root;
        endfunction

        function logic signed [DATA_W-1:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[DATA_W-1:0];
        endfunction

        function void note_input(logic [6*DATA_W-1:0] data);
            longint          obj[3];
            longint          ax[3];
            longint          goal[3];
            longint unsigned mag[3];
            longint unsigned len_sq;
            longint unsigned root;
            longint unsigned unit;
            longint unsigned off;
            int              norm_shift;
            goal_t           g;
            len_sq = 0;
            for (int i = 0; i < 3; i++) begin
                obj[i] = longint'($signed(data[i*DATA_W +: DATA_W]));
                ax[i]  = longint'($signed(data[(i+3)*DATA_W +: DATA_W]));
                mag[i] = (ax[i] < 0) ? longint'(-ax[i]) : ax[i];
                len_sq = len_sq + mag[i] * mag[i];
            end
            if (len_sq == 0) begin
                // A zero axis has no direction: the result is flagged invalid.
                g = '{gx: '0, gy: '0, gz: '0, valid: 1'b0};
            end else begin
                norm_shift = 0;
                while (norm_shift < 62 && (len_sq >> (62 - norm_shift)) == 0)
                    norm_shift += 2;
                root = int_sqrt(len_sq << norm_shift);
                for (int i = 0; i < 3; i++) begin
                    unit    = (mag[i] << (FRAC + norm_shift / 2)) / root;
                    off     = (longint'(distance) * unit) >> FRAC;
                    goal[i] = obj[i] - ((ax[i] < 0) ? -longint'(off) : longint'(off));
                end
                goal[2] = goal[2] + longint'(lift);
                g = '{gx: clamp32(goal[0]), gy: clamp32(goal[1]),
                      gz: clamp32(goal[2]), valid: 1'b1};
            end
            goals_due.push_back(g);
        endfunction

        function void check_result(logic [3*DATA_W-1:0] data, logic user);
            goal_t want;
            if (goals_due.size() == 0) begin
                $display("%0t: result with none expected: tdata %h tuser %b",
                         $time, data, user);
                errors++;
                return;
            end
            want = goals_due.pop_front();
            if (data[0 +: DATA_W] !== want.gx) begin
                $display("%0t: goal_x expected %h actual %h", $time, want.gx, data[0 +: DATA_W]);
                errors++;
            end
            if (data[DATA_W +: DATA_W] !== want.gy) begin
                $display("%0t: goal_y expected %h actual %h", $time, want.gy,
                         data[DATA_W +: DATA_W]);
                errors++;
            end
            if (data[2*DATA_W +: DATA_W] !== want.gz) begin
                $display("%0t: goal_z expected %h actual %h", $time, want.gz,
                         data[2*DATA_W +: DATA_W]);
                errors++;
            end
            if (user !== want.valid) begin
                $display("%0t: goal_valid expected %b actual %b", $time, want.valid, user);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    // object_x, object_y, object_z, axis_x, axis_y, axis_z (lowest first)
    logic [6*DATA_W-1:0]           s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    // goal_x, goal_y, goal_z (lowest first)
    logic [3*DATA_W-1:0]           m_tdata;
    // goal_valid
    logic                          m_tuser;
    logic                          cfg_we;
    logic [CFG_ADDR_W-1:0]         cfg_addr;
    logic [DATA_W-1:0]             cfg_wdata;

    goal_scoreboard sb;
    // When set, neither side idles: the closing part of the run goes at full rate.
    bit  no_idle;
    // Cycles for which the receiver keeps m_tready low regardless of bursts.
    int  hold_left;
    int  quiet_cycles;

    pregrasp_point_offset i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Both channels are sampled at the rising edge; inputs only move at the
    // falling edge, so the sampled values are always settled.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        end
    end

    // Watchdog: a long run of cycles with no item moving on either side means
    // the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WD_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver: ready most of the time, with random stall bursts, plus a long
    // forced hold-off when hold_left is loaded.
    initial begin
        int burst;
        burst    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 19);
            end
        end
    end

    task automatic write_cfg(logic [CFG_ADDR_W-1:0] idx, logic [DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Offers one item and returns at the edge that accepts it. Valid stays high
    // into the next item unless an idle burst is drawn.
    task automatic send_item(logic [6*DATA_W-1:0] data);
        int gap;
        gap = (!no_idle && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.goals_due.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Axis components are drawn from several regimes so that the normalizing
    // shift covers its whole range: full words, tiny values, zeros, extremes, +/-0x10000.
    function automatic logic [DATA_W-1:0] rand_axis();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
            3: v = '0;
            4: v = $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
            default: v = $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
        endcase
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] rand_obj();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
            1: return $signed($urandom) >>> 12;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [6*DATA_W-1:0] rand_item();
        return {rand_axis(), rand_axis(), rand_axis(), rand_obj(), rand_obj(), rand_obj()};
    endfunction

    function automatic logic [6*DATA_W-1:0] pack_item(logic [DATA_W-1:0] ox,
            logic [DATA_W-1:0] oy, logic [DATA_W-1:0] oz, logic [DATA_W-1:0] ax,
            logic [DATA_W-1:0] ay, logic [DATA_W-1:0] az);
        return {az, ay, ax, oz, oy, ox};
    endfunction

    initial begin
        logic [DATA_W-1:0] dist_set[6];
        logic [DATA_W-1:0] lift_set[6];
        sb           = new();
        sb.reset_regs();
        no_idle      = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_addr     = REG_APPROACH_DISTANCE;
        cfg_wdata    = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Register settings per phase. The first keeps the reset values. The
        // all-ones distance also checks that bit 31 of the written word is ignored.
        dist_set = '{32'h0, 32'hffffffff, 32'h1, 32'h00030000, $urandom, $urandom};
        lift_set = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hfffe8000, $urandom, $urandom};

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                write_cfg(REG_APPROACH_DISTANCE, dist_set[phase]);
                write_cfg(REG_LIFT_HEIGHT, lift_set[phase]);
            end
            if (phase == 1 || phase == 2) begin
                // Directed corners: zero axis, single-LSB axes, full-scale and
                // most-negative axes, and object words at both extremes.
                send_item(pack_item(1, 2, 3, 0, 0, 0));
                send_item(pack_item(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0));
                send_item(pack_item(0, 0, 0, 1, 0, 0));
                send_item(pack_item(0, 0, 0, 0, 32'hffffffff, 0));
                send_item(pack_item(0, 0, 0, 0, 0, 1));
                send_item(pack_item(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000));
                send_item(pack_item(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
                send_item(pack_item(32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
                send_item(pack_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                    32'h80000000, 32'h80000000, 32'h80000000));
                send_item(pack_item(32'hffffffff, 32'h00010000, 32'h7fff0000,
                                    32'h00010000, 32'h00010000, 32'h00010000));
                send_item(pack_item(32'h12345678, 32'hedcba987, 32'h0,
                                    32'h1, 32'h80000000, 32'h1));
                send_item(pack_item(32'h0, 32'h0, 32'h80000000, 32'h0, 32'h0, 32'hffff0000));
            end
            if (phase == 2) begin
                // Long receiver hold-off while items keep coming, so the
                // pipeline fills and s_tready has to drop.
                hold_left = 300;
            end
            if (phase == 5) no_idle = 1'b1;
            for (int n = 0; n < 105; n++) begin
                send_item(rand_item());
                // In phase 3 the sender pauses once mid-phase until the block is empty.
                if (phase == 3 && n == 50) drain();
            end
            drain();
        end

        if (sb.errors == 0 && sb.goals_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (sb.goals_due.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, sb.goals_due.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/ppo_pkg.sv
sv/ppo_norm.sv
sv/ppo_lane.sv
sv/ppo_merge.sv
sv/pregrasp_point_offset.sv
sv/ppo_checker.sv
verif/pregrasp_point_offset_tb.sv
